// ===== sv/rsge_pkg.sv =====
// Shared types and constants for the RGBA span gradient evaluator.
package rsge_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned FRAC_W = 17;
  localparam logic [POS_W-1:0] Q_ONE = 17'h10000;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef logic [3:0][CH_W-1:0] color_t;

  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    color_t           c0;
    color_t           c1;
  } span_t;

  typedef struct packed {
    logic             req;
    logic [POS_W-1:0] t;
    logic             alpha_nz;
    span_t            span;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } back_state_t;

endpackage

// ===== sv/rgba_span_gradient_eval_top.sv =====
// Top level of the piecewise linear RGBA span gradient evaluator.
// An add item goes straight to its result; an evaluate item scans the spans in
//   table order and, on a match, runs the serial fraction divider (which a
//   zero-width span skips) before the channel interpolation.
// Throughput: one item per back-end pass; a two-entry queue takes new items meanwhile.
// Reset (rst_n low, synchronous) empties the queue and the span count and clears
//   the transparency flag; span table contents are not cleared.
// Each result is shown for one cycle with out_valid; the receiver cannot stall it.
module rgba_span_gradient_eval_top #(
  parameter int unsigned MAX_SPANS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic signed [17:0] in_position,
  input  logic [16:0]        in_span_lo,
  input  logic [16:0]        in_span_hi,
  input  logic [7:0]         in_lo_red,
  input  logic [7:0]         in_lo_green,
  input  logic [7:0]         in_lo_blue,
  input  logic [7:0]         in_lo_alpha,
  input  logic [7:0]         in_hi_red,
  input  logic [7:0]         in_hi_green,
  input  logic [7:0]         in_hi_blue,
  input  logic [7:0]         in_hi_alpha,
  // result channel
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic               out_span_found,
  output logic               out_has_transparency,
  output logic               out_table_full
);
  import rsge_pkg::*;

  color_t  c0;
  color_t  c1;
  color_t  res_color;
  q_item_t head;
  logic    head_valid;
  logic    pop;

  // channel order inside a color: red, green, blue, alpha
  assign c0 = {in_lo_alpha, in_lo_blue, in_lo_green, in_lo_red};
  assign c1 = {in_hi_alpha, in_hi_blue, in_hi_green, in_hi_red};

  // front: clamp and queue
  rsge_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_span_lo  (in_span_lo),
    .in_span_hi  (in_span_hi),
    .in_c0       (c0),
    .in_c1       (c1),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  // back: table update or scan, divide, lerp
  rsge_back #(
    .MAX_SPANS (MAX_SPANS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (out_valid),
    .res_color  (res_color),
    .res_found  (out_span_found),
    .res_transp (out_has_transparency),
    .res_full   (out_table_full)
  );

  assign out_red   = res_color[0];
  assign out_green = res_color[1];
  assign out_blue  = res_color[2];
  assign out_alpha = res_color[3];

endmodule

// ===== sv/rsge_front.sv =====
// Front end: accepts items, clamps positions, flags alpha, and queues them.
module rsge_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic signed [17:0]       in_position,
  input  logic [16:0]              in_span_lo,
  input  logic [16:0]              in_span_hi,
  input  rsge_pkg::color_t         in_c0,
  input  rsge_pkg::color_t         in_c1,
  input  logic                     pop,
  output logic                     head_valid,
  output rsge_pkg::q_item_t        head
);
  import rsge_pkg::*;

  q_item_t    q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_item_t    item;
  logic [POS_W-1:0] t_clamp;

  // clamp to 0..1.0 in Q.16
  always_comb begin
    if (in_position[17]) begin
      t_clamp = '0;
    end else if (in_position[16] && (in_position[15:0] != 16'd0)) begin
      t_clamp = Q_ONE;
    end else begin
      t_clamp = in_position[16:0];
    end
  end

  always_comb begin
    item.req       = in_req_type;
    item.t         = t_clamp;
    item.alpha_nz  = (in_c0[3] != '0) || (in_c1[3] != '0);
    item.span.lo   = in_span_lo;
    item.span.hi   = in_span_hi;
    item.span.c0   = in_c0;
    item.span.c1   = in_c1;
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== sv/rsge_div.sv =====
// Radix-2 restoring divider for the span fraction, one quotient bit per cycle.
module rsge_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rsge_pkg::POS_W-1:0]         num,
  input  logic [rsge_pkg::POS_W-1:0]         den,
  output logic                               done,
  output logic [rsge_pkg::FRAC_W-1:0]        quo
);
  import rsge_pkg::*;

  logic [POS_W-1:0] rem_r;
  logic [POS_W-1:0] den_r;
  logic [15:0]      q_r;
  logic             qh_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [POS_W:0]   rem2;
  logic             ge;
  logic [POS_W:0]   diff;

  // num <= den, so the integer bit is 1 only when they are equal
  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});
  assign diff = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      q_r   <= '0;
      if (num == den) begin
        qh_r  <= 1'b1;
        rem_r <= '0;
      end else begin
        qh_r  <= 1'b0;
        rem_r <= num;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[POS_W-1:0] : rem2[POS_W-1:0];
      q_r   <= {q_r[14:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = {qh_r, q_r};

endmodule

// ===== sv/rsge_back.sv =====
// Back end: span table, scan, fraction divide and channel interpolation.
module rsge_back #(
  parameter int unsigned MAX_SPANS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  rsge_pkg::q_item_t       head,
  output logic                    pop,
  output logic                    res_valid,
  output rsge_pkg::color_t        res_color,
  output logic                    res_found,
  output logic                    res_transp,
  output logic                    res_full
);
  import rsge_pkg::*;

  localparam int unsigned IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SPANS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPANS);

  back_state_t state_r, state_nxt;

  span_t            mem [MAX_SPANS];
  span_t            rd_r;
  q_item_t          item_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] scan_r;
  logic             transp_r;
  logic             full_r;
  logic             found_r;
  color_t           col_r;
  logic [FRAC_W-1:0] frac_r;
  logic [1:0]       ch_r;
  logic signed [26:0] prod_r;

  logic             rd_en;
  logic             scan_end;
  logic             match;
  logic             degenerate;
  logic             div_start;
  logic             div_done;
  logic [FRAC_W-1:0] div_quo;
  logic             tbl_full;
  logic signed [8:0]  ch_diff;
  logic signed [10:0] ch_step;
  logic signed [10:0] ch_sum;

  assign tbl_full   = (cnt_r == CNT_MAX);
  assign scan_end   = (scan_r == cnt_r);
  assign match      = (item_r.t >= rd_r.lo) && (item_r.t <= rd_r.hi);
  assign degenerate = (rd_r.hi == rd_r.lo);

  rsge_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (item_r.t - rd_r.lo),
    .den   (rd_r.hi - rd_r.lo),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          state_nxt = (head.req == REQ_EVAL) ? ST_RD : ST_DONE;
        end
      end
      ST_RD:   state_nxt = scan_end ? ST_DONE : ST_CMP;
      ST_CMP: begin
        priority if (match && degenerate) begin
          state_nxt = ST_MUL;
        end else if (match) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_DIV:  state_nxt = div_done ? ST_MUL : ST_DIV;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (ch_r == 2'd3) ? ST_DONE : ST_MUL;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: pop       = head_valid;
      ST_RD:   rd_en     = !scan_end;
      ST_CMP:  div_start = match && !degenerate;
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      transp_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && (head.req == REQ_ADD) && !tbl_full) begin
        cnt_r    <= cnt_r + CNT_W'(1);
        transp_r <= transp_r | head.alpha_nz;
      end
    end
  end

  // span table
  always_ff @(posedge clk) begin
    if (pop && (head.req == REQ_ADD) && !tbl_full) begin
      mem[cnt_r[IDX_W-1:0]] <= head.span;
    end
    if (rd_en) begin
      rd_r <= mem[scan_r[IDX_W-1:0]];
    end
  end

  // channel lerp: c0 + floor((c1 - c0) * frac / 2^16)
  assign ch_diff = $signed({1'b0, rd_r.c1[ch_r]}) - $signed({1'b0, rd_r.c0[ch_r]});
  assign ch_step = prod_r[26:16];
  assign ch_sum  = $signed({3'b000, rd_r.c0[ch_r]}) + ch_step;

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r  <= head;
      scan_r  <= '0;
      col_r   <= '0;
      found_r <= 1'b0;
      full_r  <= (head.req == REQ_ADD) && tbl_full;
    end
    if ((state_r == ST_CMP) && !match) begin
      scan_r <= scan_r + CNT_W'(1);
    end
    if ((state_r == ST_CMP) && match) begin
      found_r <= 1'b1;
      frac_r  <= '0;
      ch_r    <= 2'd0;
    end
    if ((state_r == ST_DIV) && div_done) begin
      frac_r <= div_quo;
    end
    if (state_r == ST_MUL) begin
      prod_r <= 27'(ch_diff) * 27'($signed({1'b0, frac_r}));
    end
    if (state_r == ST_ACC) begin
      col_r[ch_r] <= ch_sum[7:0];
      ch_r        <= ch_r + 2'd1;
    end
  end

  assign res_color  = col_r;
  assign res_found  = found_r;
  assign res_transp = transp_r;
  assign res_full   = full_r;

endmodule
